// File: hw/rtl/sbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the absorbing-band damping core.
package sbd_pkg;

	localparam int BAND_MAX_DEF = 64;
	localparam int GRID_MAX     = 4096;

	localparam int COORD_W = $clog2(GRID_MAX);
	localparam int GRID_W  = COORD_W + 1;
	localparam int BAND_W  = 7;
	localparam int IDX_W   = 6;
	localparam int COEF_W  = 16;
	localparam int VAL_W   = 32;
	localparam int NVAL    = 4;

	localparam int IN_W        = 2 * COORD_W + IDX_W + COEF_W + NVAL * VAL_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = NVAL * VAL_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		OP_DAMP   = 2'd0,
		OP_LOAD_X = 2'd1,
		OP_LOAD_Z = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_COLS = 2'd0,
		REG_ROWS = 2'd1,
		REG_BAND = 2'd2
	} reg_idx_t;

endpackage

// File: hw/rtl/sbd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/sponge_boundary_damping_core.sv
`timescale 1ns / 1ps
// A damp transaction accepted on s_axis passes the four register stages and
// shows on m_axis from stage 4, one transaction per cycle unless m_axis_tready
// stalls the pipe; band test and table read share stage two, the four multiplies stage three.
// Table loads and unknown operations retire leaving stage one, without a result.
// Reset clears the stage valid bits and sets grid_cols/grid_rows to 256 and
// band_width to 20; the coefficient tables are not cleared and must be loaded.
module sponge_boundary_damping_core #(
	parameter int BAND_MAX = sbd_pkg::BAND_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_axis_tdata, low bit up: col, row, table_index, coef_word,
	// vel_x, vel_z, flux_x, flux_z, zero padding
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic [1:0]                       s_axis_tuser,   // operation
	// m_axis_tdata, low bit up: vel_x_out, vel_z_out, flux_x_out, flux_z_out
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tuser,   // in_band
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbd_pkg::PADDR_W-1:0]      paddr,
	input  logic [sbd_pkg::PDATA_W-1:0]      pwdata,
	output logic [sbd_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);

	localparam int AW = (BAND_MAX > 1) ? $clog2(BAND_MAX) : 1;
	localparam int DW = sbd_pkg::GRID_W + 1;
	localparam int CW = sbd_pkg::COEF_W;
	localparam int VW = sbd_pkg::VAL_W;
	localparam int NV = sbd_pkg::NVAL;
	localparam int PW = VW + CW + 1;
	localparam int QW = PW - (CW - 1);

	// Configuration registers
	logic [sbd_pkg::GRID_W-1:0] cols_q, rows_q;
	logic [sbd_pkg::BAND_W-1:0] band_q;
	logic                       cfg_wr;
	sbd_pkg::reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = sbd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= sbd_pkg::GRID_W'(256);
			rows_q <= sbd_pkg::GRID_W'(256);
			band_q <= sbd_pkg::BAND_W'(20);
		end else if (cfg_wr) begin
			case (cfg_idx)
				sbd_pkg::REG_COLS: cols_q <= pwdata[sbd_pkg::GRID_W-1:0];
				sbd_pkg::REG_ROWS: rows_q <= pwdata[sbd_pkg::GRID_W-1:0];
				sbd_pkg::REG_BAND: band_q <= pwdata[sbd_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			sbd_pkg::REG_COLS: prdata = sbd_pkg::PDATA_W'(cols_q);
			sbd_pkg::REG_ROWS: prdata = sbd_pkg::PDATA_W'(rows_q);
			sbd_pkg::REG_BAND: prdata = sbd_pkg::PDATA_W'(band_q);
			default:           prdata = '0;
		endcase
	end

	// Stage enables: a stage loads when empty or when its successor moves on
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s2, en_s3, en_s4;

	assign en_s4         = ~v_s4 | m_axis_tready;
	assign en_s3         = ~v_s3 | en_s4;
	assign en_s2         = ~v_s2 | en_s3;
	assign s_axis_tready = ~v_s1 | en_s2;

	// Stage 1: input register
	sbd_pkg::op_t                  op_s1;
	logic [sbd_pkg::COORD_W-1:0]   col_s1, row_s1;
	logic [sbd_pkg::IDX_W-1:0]     idx_s1;
	logic [CW-1:0]                 coef_s1;
	logic [NV-1:0][VW-1:0]         fld_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			op_s1   <= sbd_pkg::op_t'(s_axis_tuser);
			col_s1  <= s_axis_tdata[11:0];
			row_s1  <= s_axis_tdata[23:12];
			idx_s1  <= s_axis_tdata[29:24];
			coef_s1 <= s_axis_tdata[45:30];
			fld_s1  <= s_axis_tdata[173:46];
		end
	end

	// Band test on stage 1 contents; depths are non-negative once inside the grid
	logic [DW-1:0] c, r, cols, rows, bw, db, dr;
	logic          in_grid, top, bot, lft, rgt, band_c, selx_c;
	logic [AW-1:0] x_raddr, z_raddr;

	always_comb begin
		c  = DW'(col_s1);
		r  = DW'(row_s1);
		cols = DW'(cols_q);
		rows = DW'(rows_q);
		bw = (DW'(band_q) > DW'(BAND_MAX)) ? DW'(BAND_MAX) : DW'(band_q);
		db = rows - r - DW'(1);
		dr = cols - c - DW'(1);
		in_grid = (c < cols) && (r < rows);
		top = (r < bw) && (c >= r) && (c + r < cols);
		bot = (db < bw) && (c >= db) && (c + db < cols);
		lft = (c < bw) && (r > c) && (r + c + DW'(1) < rows);
		rgt = (dr < bw) && (r > dr) && (r + dr + DW'(1) < rows);
		band_c  = in_grid && (top || bot || lft || rgt);
		selx_c  = !top && !bot;
		z_raddr = top ? r[AW-1:0] : db[AW-1:0];
		x_raddr = lft ? c[AW-1:0] : dr[AW-1:0];
	end

	// Loads write as they leave stage 1, in stream order with the damp reads
	logic          idx_ok, we_x, we_z;
	logic [CW-1:0] x_rd, z_rd;

	assign idx_ok = DW'(idx_s1) < DW'(BAND_MAX);
	assign we_x   = v_s1 && en_s2 && (op_s1 == sbd_pkg::OP_LOAD_X) && idx_ok;
	assign we_z   = v_s1 && en_s2 && (op_s1 == sbd_pkg::OP_LOAD_Z) && idx_ok;

	sbd_ram #(
		.WIDTH(CW),
		.DEPTH(BAND_MAX)
	) u_x_table (
		.clk  (clk),
		.we   (we_x),
		.waddr(AW'(idx_s1)),
		.wdata(coef_s1),
		.re   (en_s2),
		.raddr(x_raddr),
		.rdata(x_rd)
	);

	sbd_ram #(
		.WIDTH(CW),
		.DEPTH(BAND_MAX)
	) u_z_table (
		.clk  (clk),
		.we   (we_z),
		.waddr(AW'(idx_s1)),
		.wdata(coef_s1),
		.re   (en_s2),
		.raddr(z_raddr),
		.rdata(z_rd)
	);

	// Stage 2: band decision, coefficients come out of the tables
	logic                  band_s2, selx_s2;
	logic [NV-1:0][VW-1:0] fld_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			band_s2 <= band_c;
			selx_s2 <= selx_c;
			fld_s2  <= fld_s1;
		end
	end

	// Stage 3: four products
	logic [CW-1:0]        coef_c;
	logic signed [PW-1:0] prod_c [NV];
	logic signed [PW-1:0] prod_s3 [NV];
	logic                  band_s3;
	logic [NV-1:0][VW-1:0] fld_s3;

	always_comb begin
		coef_c = selx_s2 ? x_rd : z_rd;
		for (int k = 0; k < NV; k++) begin
			prod_c[k] = PW'($signed(fld_s2[k])) * PW'($signed({1'b0, coef_c}));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			band_s3 <= band_s2;
			fld_s3  <= fld_s2;
			for (int k = 0; k < NV; k++) begin
				prod_s3[k] <= prod_c[k];
			end
		end
	end

	// Stage 4: floor shift by 15, saturate, pick scaled or raw
	logic [NV-1:0][VW-1:0] res_c;
	logic [QW-1:0]         q;

	always_comb begin
		res_c = fld_s3;
		q     = '0;
		for (int k = 0; k < NV; k++) begin
			q = prod_s3[k][PW-1:CW-1];
			if (band_s3) begin
				if (q[QW-1:VW-1] != {(QW-VW+1){q[QW-1]}}) begin
					res_c[k] = q[QW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
				end else begin
					res_c[k] = q[VW-1:0];
				end
			end
		end
	end

	logic [sbd_pkg::OUT_TDATA_W-1:0] data_s4;
	logic                            band_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			data_s4 <= res_c;
			band_s4 <= band_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = data_s4;
	assign m_axis_tuser  = band_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1 && (op_s1 == sbd_pkg::OP_DAMP);
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Loads and unknown operations never reach stage 2
	a_load_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2 && (op_s1 != sbd_pkg::OP_DAMP)) |=> !v_s2)
		else $error("non-damp transaction entered stage 2");

	// With the output register empty the whole pipe moves
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// A held stage 3 keeps its products
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s3) |=> (v_s3 && $stable(prod_s3[0]) && $stable(band_s3)))
		else $error("stage 3 lost data while stalled");

	// Table writes only happen as a valid load leaves stage 1
	a_write_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		(we_x || we_z) |-> (v_s1 && en_s2 && !(we_x && we_z)))
		else $error("table write without a load transaction");

endmodule
